@@ rtl/tto_pkg.sv @@
// Shared types and constants for the triangle overlap test pipeline.
package tto_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_NONE            = 2'd0;
    localparam kind_t KIND_EDGE            = 2'd1;
    localparam kind_t KIND_SECOND_IN_FIRST = 2'd2;
    localparam kind_t KIND_FIRST_IN_SECOND = 2'd3;

    // Edge k of a triangle runs from vertex EDGE_A[k] to vertex EDGE_B[k].
    localparam logic [1:0] EDGE_A [3] = '{2'd0, 2'd1, 2'd0};
    localparam logic [1:0] EDGE_B [3] = '{2'd1, 2'd2, 2'd2};

    typedef struct packed {
        logic pos;
        logic neg;
    } sgn_t;

    typedef struct packed {
        sgn_t [2:0][2:0] fe;
        sgn_t [2:0][2:0] se;
        sgn_t            ft;
        sgn_t            st;
        logic [2:0][2:0] fbox;
        logic [2:0][2:0] sbox;
    } geom_flags_t;

endpackage

@@ rtl/tto_orient.sv @@
// Registered orientation test: sign of the cross product (b - a) x (c - a).
module tto_orient
    import tto_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic signed [COORD_WIDTH-1:0] bx,
    input  logic signed [COORD_WIDTH-1:0] by,
    input  logic signed [COORD_WIDTH-1:0] cx,
    input  logic signed [COORD_WIDTH-1:0] cy,
    output sgn_t                          sign
);

    localparam int PW = 2 * COORD_WIDTH + 2;

    logic signed [COORD_WIDTH:0] dbx, dby, dcx, dcy;
    logic signed [PW-1:0]        prod_l_next, prod_r_next;
    logic signed [PW-1:0]        prod_l_reg, prod_r_reg;
    logic        [PW:0]          diff;

    assign dbx = {bx[COORD_WIDTH-1], bx} - {ax[COORD_WIDTH-1], ax};
    assign dby = {by[COORD_WIDTH-1], by} - {ay[COORD_WIDTH-1], ay};
    assign dcx = {cx[COORD_WIDTH-1], cx} - {ax[COORD_WIDTH-1], ax};
    assign dcy = {cy[COORD_WIDTH-1], cy} - {ay[COORD_WIDTH-1], ay};

    assign prod_l_next = dbx * dcy;
    assign prod_r_next = dby * dcx;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_l_reg <= prod_l_next;
            prod_r_reg <= prod_r_next;
        end
    end

    assign diff     = {prod_l_reg[PW-1], prod_l_reg} - {prod_r_reg[PW-1], prod_r_reg};
    assign sign.neg = diff[PW];
    assign sign.pos = !diff[PW] && (diff != '0);

endmodule

@@ rtl/tto_inbox.sv @@
// Registered bounding box test: point c within the box spanned by a and b.
module tto_inbox #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic signed [COORD_WIDTH-1:0] bx,
    input  logic signed [COORD_WIDTH-1:0] by,
    input  logic signed [COORD_WIDTH-1:0] cx,
    input  logic signed [COORD_WIDTH-1:0] cy,
    output logic                          hit
);

    logic signed [COORD_WIDTH-1:0] lx, hx, ly, hy;
    logic                          hit_next;
    logic                          hit_reg;

    assign lx = (ax < bx) ? ax : bx;
    assign hx = (ax < bx) ? bx : ax;
    assign ly = (ay < by) ? ay : by;
    assign hy = (ay < by) ? by : ay;

    assign hit_next = (cx >= lx) && (cx <= hx) && (cy >= ly) && (cy <= hy);

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

@@ rtl/tto_geom.sv @@
// Bank of orientation and box tests over both triangles, one register stage deep.
module tto_geom
    import tto_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [COORD_WIDTH-1:0] first_x  [3],
    input  logic signed [COORD_WIDTH-1:0] first_y  [3],
    input  logic signed [COORD_WIDTH-1:0] second_x [3],
    input  logic signed [COORD_WIDTH-1:0] second_y [3],
    output geom_flags_t                   flags
);

    sgn_t fe_sign [3][3];
    sgn_t se_sign [3][3];
    sgn_t ft_sign, st_sign;
    logic fbox_hit [3][3];
    logic sbox_hit [3][3];

    for (genvar i = 0; i < 3; i++) begin : g_edge
        for (genvar v = 0; v < 3; v++) begin : g_vert
            tto_orient #(.COORD_WIDTH(COORD_WIDTH)) u_fe (
                .aclk (aclk),
                .en   (en),
                .ax   (first_x[EDGE_A[i]]),
                .ay   (first_y[EDGE_A[i]]),
                .bx   (first_x[EDGE_B[i]]),
                .by   (first_y[EDGE_B[i]]),
                .cx   (second_x[v]),
                .cy   (second_y[v]),
                .sign (fe_sign[i][v])
            );

            tto_orient #(.COORD_WIDTH(COORD_WIDTH)) u_se (
                .aclk (aclk),
                .en   (en),
                .ax   (second_x[EDGE_A[i]]),
                .ay   (second_y[EDGE_A[i]]),
                .bx   (second_x[EDGE_B[i]]),
                .by   (second_y[EDGE_B[i]]),
                .cx   (first_x[v]),
                .cy   (first_y[v]),
                .sign (se_sign[i][v])
            );

            tto_inbox #(.COORD_WIDTH(COORD_WIDTH)) u_fbox (
                .aclk (aclk),
                .en   (en),
                .ax   (first_x[EDGE_A[i]]),
                .ay   (first_y[EDGE_A[i]]),
                .bx   (first_x[EDGE_B[i]]),
                .by   (first_y[EDGE_B[i]]),
                .cx   (second_x[v]),
                .cy   (second_y[v]),
                .hit  (fbox_hit[i][v])
            );

            tto_inbox #(.COORD_WIDTH(COORD_WIDTH)) u_sbox (
                .aclk (aclk),
                .en   (en),
                .ax   (second_x[EDGE_A[i]]),
                .ay   (second_y[EDGE_A[i]]),
                .bx   (second_x[EDGE_B[i]]),
                .by   (second_y[EDGE_B[i]]),
                .cx   (first_x[v]),
                .cy   (first_y[v]),
                .hit  (sbox_hit[i][v])
            );

            assign flags.fe[i][v]   = fe_sign[i][v];
            assign flags.se[i][v]   = se_sign[i][v];
            assign flags.fbox[i][v] = fbox_hit[i][v];
            assign flags.sbox[i][v] = sbox_hit[i][v];
        end
    end

    tto_orient #(.COORD_WIDTH(COORD_WIDTH)) u_ft (
        .aclk (aclk),
        .en   (en),
        .ax   (first_x[0]),
        .ay   (first_y[0]),
        .bx   (first_x[1]),
        .by   (first_y[1]),
        .cx   (first_x[2]),
        .cy   (first_y[2]),
        .sign (ft_sign)
    );

    tto_orient #(.COORD_WIDTH(COORD_WIDTH)) u_st (
        .aclk (aclk),
        .en   (en),
        .ax   (second_x[0]),
        .ay   (second_y[0]),
        .bx   (second_x[1]),
        .by   (second_y[1]),
        .cx   (second_x[2]),
        .cy   (second_y[2]),
        .sign (st_sign)
    );

    assign flags.ft = ft_sign;
    assign flags.st = st_sign;

endmodule

@@ rtl/tto_decide.sv @@
// Combines the test flags into the contact kind, edge checks taking priority.
module tto_decide
    import tto_pkg::*;
(
    input  geom_flags_t flags,
    output kind_t       kind
);

    logic [8:0] pair_hit;
    logic [2:0] s_in_f;
    logic [2:0] f_in_s;

    function automatic logic is_zero(input sgn_t s);
        return !s.pos && !s.neg;
    endfunction

    // The last edge in EDGE_A/EDGE_B runs from the first vertex to the last one, so its sign is reversed
    // relative to the closing edge of the triangle walk.
    function automatic logic in_tri(input sgn_t t, input sgn_t d0, input sgn_t d1,
                                    input sgn_t d2, input logic b0, input logic b1,
                                    input logic b2);
        logic has_neg;
        logic has_pos;
        has_neg = d0.neg || d1.neg || d2.pos;
        has_pos = d0.pos || d1.pos || d2.neg;
        if (is_zero(t)) begin
            return (is_zero(d0) && b0) || (is_zero(d1) && b1) || (is_zero(d2) && b2);
        end
        return !(has_neg && has_pos);
    endfunction

    for (genvar i = 0; i < 3; i++) begin : g_fedge
        for (genvar j = 0; j < 3; j++) begin : g_sedge
            sgn_t o1, o2, o3, o4;
            logic crossing, touch;

            assign o1 = flags.fe[i][EDGE_A[j]];
            assign o2 = flags.fe[i][EDGE_B[j]];
            assign o3 = flags.se[j][EDGE_A[i]];
            assign o4 = flags.se[j][EDGE_B[i]];

            assign crossing = ((o1.pos && o2.neg) || (o1.neg && o2.pos)) &&
                              ((o3.pos && o4.neg) || (o3.neg && o4.pos));
            assign touch = (is_zero(o1) && flags.fbox[i][EDGE_A[j]]) ||
                           (is_zero(o2) && flags.fbox[i][EDGE_B[j]]) ||
                           (is_zero(o3) && flags.sbox[j][EDGE_A[i]]) ||
                           (is_zero(o4) && flags.sbox[j][EDGE_B[i]]);

            assign pair_hit[i*3+j] = crossing || touch;
        end
    end

    for (genvar v = 0; v < 3; v++) begin : g_vert
        assign s_in_f[v] = in_tri(flags.ft, flags.fe[0][v], flags.fe[1][v], flags.fe[2][v],
                                  flags.fbox[0][v], flags.fbox[1][v], flags.fbox[2][v]);
        assign f_in_s[v] = in_tri(flags.st, flags.se[0][v], flags.se[1][v], flags.se[2][v],
                                  flags.sbox[0][v], flags.sbox[1][v], flags.sbox[2][v]);
    end

    always_comb begin
        priority if (|pair_hit) begin
            kind = KIND_EDGE;
        end else if (|s_in_f) begin
            kind = KIND_SECOND_IN_FIRST;
        end else if (|f_in_s) begin
            kind = KIND_FIRST_IN_SECOND;
        end else begin
            kind = KIND_NONE;
        end
    end

endmodule

@@ rtl/triangle_overlap_test.sv @@
// Triangle pair overlap test: top level with the stream handshake and pipeline control.
//
// Each input word on the s_ channel carries two triangles, six signed coordinates
// apiece, and yields exactly one output word on the m_ channel: a collide bit and
// the kind of the first test that found contact (edge meeting, a vertex of the
// second triangle in the first, or a vertex of the first in the second).
// The pipeline has three register stages: the input register, the product
// registers inside the orientation units, and the result register. A word
// passes through them in that order, and a new word can be accepted every
// cycle while m_tready is high.
// Every stage moves forward when it is empty or when the stage after it moves,
// so bubbles close up while m_tready is low and s_tready only falls once all
// three stages hold words. Nothing is lost or repeated under stalls.
// A synchronous reset with aresetn low empties all stages; m_tvalid is low
// after it and no state carries between words.
module triangle_overlap_test
    import tto_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // first_x0, first_y0, first_x1, first_y1, first_x2, first_y2,
    // second_x0, second_y0, second_x1, second_y1, second_x2, second_y2
    input  logic [((12*COORD_WIDTH+7)/8)*8-1:0]          s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // collide, contact_kind, zero fill
    output logic [7:0]                                  m_tdata
);

    logic                          in_valid_reg, in_valid_next;
    logic                          mid_valid_reg, mid_valid_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          load_in, load_mid, load_out;
    logic signed [COORD_WIDTH-1:0] first_x_reg  [3];
    logic signed [COORD_WIDTH-1:0] first_y_reg  [3];
    logic signed [COORD_WIDTH-1:0] second_x_reg [3];
    logic signed [COORD_WIDTH-1:0] second_y_reg [3];
    geom_flags_t                   flags;
    kind_t                         kind;
    kind_t                         kind_reg;
    logic                          collide_reg;

    assign load_out = !out_valid_reg || m_tready;
    assign load_mid = !mid_valid_reg || load_out;
    assign load_in  = !in_valid_reg || load_mid;

    assign in_valid_next  = load_in  ? s_tvalid      : in_valid_reg;
    assign mid_valid_next = load_mid ? in_valid_reg  : mid_valid_reg;
    assign out_valid_next = load_out ? mid_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_in) begin
            for (int v = 0; v < 3; v++) begin
                first_x_reg[v]  <= s_tdata[(2*v)*COORD_WIDTH +: COORD_WIDTH];
                first_y_reg[v]  <= s_tdata[(2*v+1)*COORD_WIDTH +: COORD_WIDTH];
                second_x_reg[v] <= s_tdata[(6+2*v)*COORD_WIDTH +: COORD_WIDTH];
                second_y_reg[v] <= s_tdata[(7+2*v)*COORD_WIDTH +: COORD_WIDTH];
            end
        end
    end

    tto_geom #(.COORD_WIDTH(COORD_WIDTH)) u_geom (
        .aclk     (aclk),
        .en       (load_mid),
        .first_x  (first_x_reg),
        .first_y  (first_y_reg),
        .second_x (second_x_reg),
        .second_y (second_y_reg),
        .flags    (flags)
    );

    tto_decide u_decide (
        .flags (flags),
        .kind  (kind)
    );

    always_ff @(posedge aclk) begin
        if (load_out) begin
            kind_reg    <= kind;
            collide_reg <= (kind != KIND_NONE);
        end
    end

    assign s_tready = load_in;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, kind_reg, collide_reg};

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && mid_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while all stages are full and stalled");

    a_mid_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && load_mid) |=> mid_valid_reg)
        else $error("word lost between input and product stage");

    a_out_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (mid_valid_reg && load_out) |=> m_tvalid)
        else $error("word lost between product stage and result register");

    a_collide_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] != KIND_NONE)))
        else $error("collide bit disagrees with contact kind");

endmodule
